/* rtl/alt_pkg.sv */
// alt_pkg: shared constants, command codes and types for the array list table.
// No dependencies; every other file of the block but alt_ram imports this package.
package alt_pkg;

   localparam int CAPACITY = 128;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 7;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 8;

   localparam logic [CMD_W-1:0] CMD_SEARCH      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE_LAST = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE_AT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND_DELETE = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               ok;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] count;
   } res_type;

endpackage

/* rtl/alt_req_if.sv */
// alt_req_if: command channel (valid/ready plus command payload).
// Depends on alt_pkg.
interface alt_req_if;
   import alt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic signed [VALUE_W-1:0] value;
   logic [INDEX_W-1:0]        index;

   modport source (output valid, output command, output value, output index, input ready);
   modport sink   (input valid, input command, input value, input index, output ready);
endinterface

/* rtl/alt_rsp_if.sv */
// alt_rsp_if: result channel (valid/ready plus result payload).
// Depends on alt_pkg.
interface alt_rsp_if;
   import alt_pkg::*;

   logic               valid;
   logic               ready;
   logic               ok;
   logic [POS_W-1:0]   position;
   logic [COUNT_W-1:0] count;

   modport source (output valid, output ok, output position, output count, input ready);
   modport sink   (input valid, input ok, input position, input count, output ready);
endinterface

/* rtl/alt_ram.sv */
// alt_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module alt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/alt_ctrl.sv */
// alt_ctrl: command sequencer, entry count, and the pipelined memory walk
// shared by search and compaction. Depends on alt_pkg, alt_req_if.
module alt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   alt_req_if.sink                  req_if,
   output logic                     res_valid,
   output alt_pkg::res_type         res,
   input  logic                     can_load,
   output logic                     ram_wr_en,
   output logic [alt_pkg::ADDR_W-1:0]  ram_wr_addr,
   output logic [alt_pkg::VALUE_W-1:0] ram_wr_data,
   output logic                     ram_rd_en,
   output logic [alt_pkg::ADDR_W-1:0]  ram_rd_addr,
   input  logic [alt_pkg::VALUE_W-1:0] ram_rd_data
);
   import alt_pkg::*;

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   addr_ff, addr_in;       // next address to read
   logic               chk_ff, chk_in;         // read data valid this cycle
   logic [CNT_W-1:0]   chk_addr_ff, chk_addr_in;
   logic               ok_ff, ok_in;
   logic [POS_W-1:0]   pos_ff, pos_in;

   logic               issue_en;
   logic               hit;
   logic               walk_end;
   logic [CNT_W-1:0]   shift_dst;

   assign issue_en  = addr_ff < count_ff;
   assign hit       = chk_ff && (ram_rd_data == value_ff);
   assign walk_end  = !chk_ff && !issue_en;
   assign shift_dst = chk_addr_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         chk_ff   <= chk_in;
      end
      cmd_ff      <= cmd_in;
      value_ff    <= value_in;
      addr_ff     <= addr_in;
      chk_addr_ff <= chk_addr_in;
      ok_ff       <= ok_in;
      pos_ff      <= pos_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      value_in    = value_ff;
      count_in    = count_ff;
      addr_in     = addr_ff;
      chk_in      = chk_ff;
      chk_addr_in = chk_addr_ff;
      ok_in       = ok_ff;
      pos_in      = pos_ff;

      req_if.ready = 1'b0;
      res_valid    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_ff[ADDR_W-1:0];
      ram_wr_data  = req_if.value;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = addr_ff[ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               cmd_in   = req_if.command;
               value_in = req_if.value;
               ok_in    = 1'b0;
               pos_in   = '0;
               chk_in   = 1'b0;
               state_in = ST_DONE;
               case (req_if.command)
                  CMD_SEARCH, CMD_FIND_DELETE: begin
                     addr_in  = '0;
                     state_in = ST_SCAN;
                  end
                  CMD_APPEND: begin
                     if (count_ff < CNT_W'(CAPACITY)) begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                        ok_in     = 1'b1;
                     end
                  end
                  CMD_REMOVE_LAST: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - CNT_W'(1);
                        ok_in    = 1'b1;
                     end
                  end
                  CMD_DELETE_AT: begin
                     if (CNT_W'(req_if.index) < count_ff) begin
                        addr_in  = CNT_W'(req_if.index) + CNT_W'(1);
                        state_in = ST_SHIFT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            ram_rd_en   = issue_en;
            chk_in      = issue_en;
            chk_addr_in = addr_ff;
            addr_in     = addr_ff + CNT_W'(1);
            if (hit) begin
               if (cmd_ff == CMD_SEARCH) begin
                  ok_in    = 1'b1;
                  pos_in   = chk_addr_ff[POS_W-1:0];
                  state_in = ST_DONE;
               end else begin
                  // matched entry becomes the hole to close
                  addr_in  = chk_addr_ff + CNT_W'(1);
                  chk_in   = 1'b0;
                  state_in = ST_SHIFT;
               end
            end else if (walk_end) begin
               state_in = ST_DONE;
            end
         end

         ST_SHIFT: begin
            ram_rd_en   = issue_en;
            chk_in      = issue_en;
            chk_addr_in = addr_ff;
            addr_in     = addr_ff + CNT_W'(1);
            // entry read last cycle moves down one slot
            ram_wr_en   = chk_ff;
            ram_wr_addr = shift_dst[ADDR_W-1:0];
            ram_wr_data = ram_rd_data;
            if (walk_end) begin
               count_in = count_ff - CNT_W'(1);
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            res_valid = 1'b1;
            if (can_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res.ok       = ok_ff;
   assign res.position = pos_ff;
   assign res.count    = COUNT_W'(count_ff);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_shift_wr_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && ram_wr_en) |-> (shift_dst < count_ff))
      else $error("compaction write beyond live entries");

   a_wr_source: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ((state_ff == ST_IDLE && req_if.valid && cmd_in == CMD_APPEND)
                     || state_ff == ST_SHIFT))
      else $error("memory write outside append or compaction");

   a_done_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && can_load) |=> (state_ff == ST_IDLE))
      else $error("result handed off but sequencer not idle");

endmodule

/* rtl/alt_out.sv */
// alt_out: result output register between the sequencer and the result channel.
// Depends on alt_pkg, alt_rsp_if.
module alt_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             res_valid,
   input  alt_pkg::res_type res,
   output logic             can_load,
   alt_rsp_if.source        rsp_if
);
   import alt_pkg::*;

   logic    valid_ff, valid_in;
   res_type data_ff, data_in;
   logic    load;

   assign can_load = !valid_ff || rsp_if.ready;
   assign load     = res_valid && can_load;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = res;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_if.valid    = valid_ff;
   assign rsp_if.ok       = data_ff.ok;
   assign rsp_if.position = data_ff.position;
   assign rsp_if.count    = data_ff.count;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(load && valid_ff && !rsp_if.ready))
      else $error("pending result overwritten");

endmodule

/* rtl/array_list_table.sv */
// array_list_table: top level of the packed list with compacting delete.
// Depends on alt_pkg, alt_req_if, alt_rsp_if, alt_ram, alt_ctrl, alt_out.
//
//  channel   dir  handshake     payload
//  req_if    in   valid/ready   command[2:0], value[31:0] signed, index[6:0]
//  rsp_if    out  valid/ready   ok, position[6:0], count[7:0]
//
// One command at a time. Append, remove last, bad index and unknown codes:
// the result passes through the done state into the output register. Search
// and find-and-delete stream reads through the entry RAM one per cycle
// (registered read); compaction moves one entry per cycle through the same
// read/write ports.
// Reset is synchronous; it clears the count and control only, the entry RAM
// is not cleared since only entries below the count are ever read.
// A stalled result sits in the output register; the next command is taken
// meanwhile and finishes once that register frees.
module array_list_table (
   input  logic      clock,
   input  logic      reset,
   alt_req_if.sink   req_if,
   alt_rsp_if.source rsp_if
);
   import alt_pkg::*;

   logic               res_valid;
   res_type            res;
   logic               can_load;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   // entry storage
   alt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // command sequencer and memory walk
   alt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .res_valid   (res_valid),
      .res         (res),
      .can_load    (can_load),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // result register toward the consumer
   alt_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .can_load  (can_load),
      .rsp_if    (rsp_if)
   );

endmodule
